FILE: hdl/lcmpf_pkg.sv
// Shared types, constants and the prime tables of the LCM-by-factoring block.
package lcmpf_pkg;

    localparam int PRIME_COUNT = 168;
    localparam int PRIME_LIMIT = 1000;

    localparam int PRIME_W = $clog2(PRIME_LIMIT);
    localparam int PIDX_W  = $clog2(PRIME_COUNT);
    localparam int IDX_W   = $clog2(PRIME_COUNT + 1);

    localparam int VALUE_W    = 32;
    localparam int MULTIPLE_W = 31;
    localparam int STATUS_W   = 2;
    localparam int CHECK_W    = VALUE_W + PRIME_W;
    localparam int WIDE_W     = MULTIPLE_W + PRIME_W;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND   = 2'd2;

    typedef logic [PRIME_W-1:0] prime_t;
    typedef logic [VALUE_W-1:0] word_t;
    typedef prime_t prime_tab_t [PRIME_COUNT];
    typedef word_t  inv_tab_t [PRIME_COUNT];

    // Every prime below the limit, rising.
    localparam prime_tab_t PRIMES = '{
        10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
        10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
        10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
        10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
        10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
        10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
        10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
        10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
        10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
        10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
        10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
        10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
        10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
        10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
        10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
        10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
        10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
        10'd773, 10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827,
        10'd829, 10'd839, 10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881,
        10'd883, 10'd887, 10'd907, 10'd911, 10'd919, 10'd929, 10'd937, 10'd941,
        10'd947, 10'd953, 10'd967, 10'd971, 10'd977, 10'd983, 10'd991, 10'd997
    };

    // Inverse of each odd prime modulo 2^32 by Newton iteration; every step
    // doubles the number of correct low bits, starting from three.
    function automatic inv_tab_t build_inverses(input prime_tab_t primes);
        inv_tab_t tab;
        word_t    p;
        word_t    inv;
        for (int i = 0; i < PRIME_COUNT; i++) begin
            p   = word_t'(primes[i]);
            inv = p;
            for (int k = 0; k < 4; k++) begin
                inv = word_t'(inv * word_t'(word_t'(2) - word_t'(p * inv)));
            end
            tab[i] = inv;
        end
        return tab;
    endfunction

    localparam inv_tab_t PRIME_INVERSES = build_inverses(PRIMES);

    typedef struct packed {
        logic load;
        logic calc;
        logic apply;
        logic next;
        logic finish;
    } lcmpf_cmd_t;

    typedef struct packed {
        logic both_one;
        logic table_end;
        logic hit;
        logic out_busy;
    } lcmpf_stat_t;

endpackage

FILE: hdl/lcmpf_ctrl.sv
// Controller state machine that sequences the trial division over the prime table.
module lcmpf_ctrl
    import lcmpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  lcmpf_stat_t stat,
    output lcmpf_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_TEST = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (stat.both_one || stat.table_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.calc   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                // A hit divides out one more power and retries the same prime.
                if (stat.hit) begin
                    cmd.apply = 1'b1;
                end else begin
                    cmd.next = 1'b1;
                end
                state_next = ST_CALC;
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/lcmpf_dp.sv
// Datapath: operand cofactors, exact-division test, running product and result register.
module lcmpf_dp
    import lcmpf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [VALUE_W-1:0]    first_value,
    input  logic [VALUE_W-1:0]    second_value,
    input  lcmpf_cmd_t            cmd,
    output lcmpf_stat_t           stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MULTIPLE_W-1:0] multiple,
    output logic [STATUS_W-1:0]   status
);

    logic [VALUE_W-1:0]    ma_reg, mb_reg;
    logic [VALUE_W-1:0]    qa_reg, qb_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [MULTIPLE_W-1:0] prod_reg;
    logic                  ovf_reg;
    logic [MULTIPLE_W-1:0] mult_reg;
    logic [STATUS_W-1:0]   stat_reg;
    logic                  valid_reg;

    logic [PIDX_W-1:0]     sel;
    prime_t                cur_prime;
    word_t                 cur_inv;
    logic                  is_two;
    logic [VALUE_W-1:0]    mag_a, mag_b;
    logic [VALUE_W-1:0]    qa_calc, qb_calc;
    logic [CHECK_W-1:0]    back_a, back_b;
    logic                  div_a, div_b;
    logic [WIDE_W-1:0]     wide;
    logic                  wide_ovf;
    logic                  beyond;

    function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] m;
        m = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
        if (m == '0) begin
            m = VALUE_W'(1);
        end
        return m;
    endfunction

    // The index only reaches the table size once the sweep is over.
    assign sel       = idx_reg[PIDX_W-1:0];
    assign cur_prime = PRIMES[sel];
    assign cur_inv   = PRIME_INVERSES[sel];
    assign is_two    = (idx_reg == '0);

    assign mag_a = magnitude(first_value);
    assign mag_b = magnitude(second_value);

    // For an odd prime, x times its inverse mod 2^32 is x/p exactly when p divides x.
    assign qa_calc = is_two ? {1'b0, ma_reg[VALUE_W-1:1]} : VALUE_W'(ma_reg * cur_inv);
    assign qb_calc = is_two ? {1'b0, mb_reg[VALUE_W-1:1]} : VALUE_W'(mb_reg * cur_inv);

    // The candidate quotient is the true one only if it multiplies back without wrap.
    assign back_a = CHECK_W'(qa_reg) * CHECK_W'(cur_prime);
    assign back_b = CHECK_W'(qb_reg) * CHECK_W'(cur_prime);
    assign div_a  = (back_a == CHECK_W'(ma_reg)) && (ma_reg > VALUE_W'(1));
    assign div_b  = (back_b == CHECK_W'(mb_reg)) && (mb_reg > VALUE_W'(1));

    assign wide     = WIDE_W'(prod_reg) * WIDE_W'(cur_prime);
    assign wide_ovf = (wide[WIDE_W-1:MULTIPLE_W] != '0);

    assign beyond = (ma_reg > VALUE_W'(1)) || (mb_reg > VALUE_W'(1));

    assign stat.both_one  = (ma_reg == VALUE_W'(1)) && (mb_reg == VALUE_W'(1));
    assign stat.table_end = (idx_reg == IDX_W'(PRIME_COUNT));
    assign stat.hit       = div_a || div_b;
    assign stat.out_busy  = valid_reg && !out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ma_reg   <= mag_a;
            mb_reg   <= mag_b;
            prod_reg <= MULTIPLE_W'(1);
        end
        if (cmd.calc) begin
            qa_reg <= qa_calc;
            qb_reg <= qb_calc;
        end
        if (cmd.apply) begin
            if (div_a) begin
                ma_reg <= qa_reg;
            end
            if (div_b) begin
                mb_reg <= qb_reg;
            end
            if (!ovf_reg && !wide_ovf) begin
                prod_reg <= wide[MULTIPLE_W-1:0];
            end
        end
        if (cmd.finish) begin
            if (beyond) begin
                stat_reg <= STATUS_BEYOND;
                mult_reg <= '0;
            end else if (ovf_reg) begin
                stat_reg <= STATUS_OVERFLOW;
                mult_reg <= '0;
            end else begin
                stat_reg <= STATUS_OK;
                mult_reg <= prod_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg <= '0;
                ovf_reg <= 1'b0;
            end else if (cmd.next) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.apply && !ovf_reg && wide_ovf) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.finish) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign multiple  = mult_reg;
    assign status    = stat_reg;

endmodule

FILE: hdl/lcm_by_prime_factoring_top.sv
// The input transfer is loaded, then each table prime tried takes a compute and a test step,
// each prime power in the result one more such pair, and the result is then loaded for m_tvalid.
// Throughput: one item at a time; the next input transfer is taken once the previous
// result has been loaded into the output register, which may still be waiting on m_tready.
// Reset: synchronous active-low aresetn returns the controller to idle and empties the
// output register.
module lcm_by_prime_factoring_top
    import lcmpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] first_value, [63:32] second_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [30:0] multiple, [32:31] status, [39:33] zero
);

    lcmpf_cmd_t            cmd;
    lcmpf_stat_t           stat;
    logic [MULTIPLE_W-1:0] multiple;
    logic [STATUS_W-1:0]   status;

    lcmpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcmpf_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .first_value  (s_tdata[31:0]),
        .second_value (s_tdata[63:32]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .multiple     (multiple),
        .status       (status)
    );

    assign m_tdata = {7'd0, status, multiple};

endmodule
